/* sv/efs_pkg.sv */
// ----------------------------------------------------------------------------
// efs_pkg
// Shared types and constants for the elevator floor scheduler: the controller
// state codes, the packed poll item and the stream widths.
// ----------------------------------------------------------------------------
package efs_pkg;

    localparam int DEFAULT_FLOOR_COUNT = 4;

    localparam int CTRL_W     = 2;
    localparam int BUTTON_W   = 4;
    localparam int FLOOR_IN_W = 3;
    localparam int TARGET_W   = 4;

    localparam int NO_TARGET = -1;

    typedef enum logic [CTRL_W-1:0] {
        CTRL_INIT = 2'd0,
        CTRL_WAIT = 2'd1,
        CTRL_STOP = 2'd2,
        CTRL_MOVE = 2'd3
    } ctrl_state_t;

    // First member is the most significant, so ctrl_state lands in the low bits.
    typedef struct packed {
        logic [FLOOR_IN_W-1:0] current_floor;
        logic [FLOOR_IN_W-1:0] last_floor;
        logic [BUTTON_W-1:0]   hall_down_buttons;
        logic [BUTTON_W-1:0]   hall_up_buttons;
        logic [BUTTON_W-1:0]   cab_buttons;
        ctrl_state_t           ctrl_state;
    } efs_item_t;

    localparam int ITEM_W    = $bits(efs_item_t);
    localparam int S_TDATA_W = ((ITEM_W + 7) / 8) * 8;
    localparam int RESULT_W  = TARGET_W + 1;
    localparam int M_TDATA_W = ((RESULT_W + 7) / 8) * 8;

endpackage

/* sv/efs_core.sv */
// ----------------------------------------------------------------------------
// efs_core
// Order masks, travel direction and target register. On each step outside the
// init state the item is latched into the masks and the next target chosen in one pass.
// ----------------------------------------------------------------------------
module efs_core #(
    parameter int FLOOR_COUNT = efs_pkg::DEFAULT_FLOOR_COUNT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                step,
    input  efs_pkg::efs_item_t                  item,
    output logic signed [efs_pkg::TARGET_W-1:0] target_floor,
    output logic                                heading_up
);

    localparam int FW = $clog2(FLOOR_COUNT + 1);
    localparam int TW = FW + 1;

    logic [FLOOR_COUNT-1:0] cab_orders_reg,  cab_orders_next;
    logic [FLOOR_COUNT-1:0] up_orders_reg,   up_orders_next;
    logic [FLOOR_COUNT-1:0] down_orders_reg, down_orders_next;
    logic                   direction_up_reg, direction_up_next;
    logic signed [TW-1:0]   target_reg,       target_next;

    logic [FLOOR_COUNT-1:0] cab_btn, up_btn, down_btn, keep_mask, hall;
    logic [FW-1:0]          last_sat, su_cab, sd_cab, su_hall, sd_hall;
    logic [FW-1:0]          cab_pick, hall_pick, ovr_up, ovr_down;
    logic                   cab_dir, hall_dir;

    // Spread a button field over the floors; bits beyond the top floor drop.
    function automatic logic [FLOOR_COUNT-1:0] widen(input logic [efs_pkg::BUTTON_W-1:0] b);
        logic [FLOOR_COUNT-1:0] m;
        m = '0;
        for (int i = 0; i < FLOOR_COUNT; i++) begin
            if (i < efs_pkg::BUTTON_W) begin
                m[i] = b[i];
            end
        end
        return m;
    endfunction

    // Lowest floor at or above from with an order, 0 if none.
    function automatic logic [FW-1:0] scan_up(input logic [FLOOR_COUNT-1:0] m,
                                              input logic [FW-1:0] from);
        logic [FW-1:0] hit;
        hit = '0;
        for (int i = FLOOR_COUNT - 1; i >= 0; i--) begin
            if (m[i] && (i + 1 >= int'(from))) begin
                hit = FW'(i + 1);
            end
        end
        return hit;
    endfunction

    // Highest floor at or below from with an order, 0 if none.
    function automatic logic [FW-1:0] scan_down(input logic [FLOOR_COUNT-1:0] m,
                                                input logic [FW-1:0] from);
        logic [FW-1:0] hit;
        hit = '0;
        for (int i = 0; i < FLOOR_COUNT; i++) begin
            if (m[i] && (i + 1 <= int'(from))) begin
                hit = FW'(i + 1);
            end
        end
        return hit;
    endfunction

    // Lowest floor in [from, tgt-1] with an order, 0 if none.
    function automatic logic [FW-1:0] pass_up(input logic [FLOOR_COUNT-1:0] m,
                                              input logic [FW-1:0] from,
                                              input logic [FW-1:0] tgt);
        logic [FW-1:0] hit;
        hit = '0;
        for (int i = FLOOR_COUNT - 1; i >= 0; i--) begin
            if (m[i] && (i + 1 >= int'(from)) && (i + 1 < int'(tgt))) begin
                hit = FW'(i + 1);
            end
        end
        return hit;
    endfunction

    // Highest floor in [tgt+1, from] with an order, 0 if none.
    function automatic logic [FW-1:0] pass_down(input logic [FLOOR_COUNT-1:0] m,
                                                input logic [FW-1:0] from,
                                                input logic [FW-1:0] tgt);
        logic [FW-1:0] hit;
        hit = '0;
        for (int i = 0; i < FLOOR_COUNT; i++) begin
            if (m[i] && (i + 1 <= int'(from)) && (i + 1 > int'(tgt))) begin
                hit = FW'(i + 1);
            end
        end
        return hit;
    endfunction

    always_comb begin
        cab_btn  = widen(item.cab_buttons);
        up_btn   = widen(item.hall_up_buttons);
        down_btn = widen(item.hall_down_buttons);
        // No up call from the top floor, no down call from the bottom one.
        up_btn[FLOOR_COUNT-1] = 1'b0;
        down_btn[0]           = 1'b0;

        keep_mask = '1;
        if (item.ctrl_state == efs_pkg::CTRL_WAIT || item.ctrl_state == efs_pkg::CTRL_STOP) begin
            for (int i = 0; i < FLOOR_COUNT; i++) begin
                if (int'(item.current_floor) == i + 1) begin
                    keep_mask[i] = 1'b0;
                end
            end
        end

        if (int'(item.last_floor) > FLOOR_COUNT) begin
            last_sat = FW'(FLOOR_COUNT);
        end else begin
            last_sat = FW'(item.last_floor);
        end

        cab_orders_next  = (cab_orders_reg  | cab_btn)  & keep_mask;
        up_orders_next   = (up_orders_reg   | up_btn)   & keep_mask;
        down_orders_next = (down_orders_reg | down_btn) & keep_mask;
        hall = up_orders_next | down_orders_next;

        su_cab  = scan_up(cab_orders_next, last_sat);
        sd_cab  = scan_down(cab_orders_next, last_sat);
        su_hall = scan_up(hall, last_sat);
        sd_hall = scan_down(hall, last_sat);

        // Keep heading if something lies ahead, otherwise turn around.
        if (direction_up_reg && su_cab != '0) begin
            cab_pick = su_cab;
            cab_dir  = 1'b1;
        end else if (direction_up_reg || sd_cab != '0) begin
            cab_pick = sd_cab;
            cab_dir  = 1'b0;
        end else begin
            cab_pick = su_cab;
            cab_dir  = 1'b1;
        end

        if (direction_up_reg && su_hall != '0) begin
            hall_pick = su_hall;
            hall_dir  = 1'b1;
        end else if (direction_up_reg || sd_hall != '0) begin
            hall_pick = sd_hall;
            hall_dir  = 1'b0;
        end else begin
            hall_pick = su_hall;
            hall_dir  = 1'b1;
        end

        ovr_up   = pass_up(up_orders_next, last_sat, cab_pick);
        ovr_down = pass_down(down_orders_next, last_sat, cab_pick);

        direction_up_next = direction_up_reg;
        target_next       = target_reg;
        if (item.ctrl_state != efs_pkg::CTRL_INIT) begin
            if (cab_orders_next != '0) begin
                direction_up_next = cab_dir;
                target_next       = TW'(cab_pick);
                // A hall call on the way in the travel direction comes first.
                if (cab_dir && ovr_up != '0) begin
                    target_next = TW'(ovr_up);
                end else if (!cab_dir && ovr_down != '0) begin
                    target_next = TW'(ovr_down);
                end
            end else if (hall != '0) begin
                direction_up_next = hall_dir;
                if (hall_pick != '0) begin
                    target_next = TW'(hall_pick);
                end
            end else begin
                target_next = TW'(efs_pkg::NO_TARGET);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cab_orders_reg   <= '0;
            up_orders_reg    <= '0;
            down_orders_reg  <= '0;
            direction_up_reg <= 1'b0;
            target_reg       <= TW'(efs_pkg::NO_TARGET);
        end else if (step && item.ctrl_state != efs_pkg::CTRL_INIT) begin
            cab_orders_reg   <= cab_orders_next;
            up_orders_reg    <= up_orders_next;
            down_orders_reg  <= down_orders_next;
            direction_up_reg <= direction_up_next;
            target_reg       <= target_next;
        end
    end

    assign target_floor = efs_pkg::TARGET_W'(int'(target_reg));
    assign heading_up   = direction_up_reg;

endmodule

/* sv/elevator_floor_scheduler.sv */
// ----------------------------------------------------------------------------
// elevator_floor_scheduler
// Latches hall and cab calls into order masks and picks the next floor to
// serve with SCAN-style scheduling, one poll item in, one result item out.
// ----------------------------------------------------------------------------
// An accepted item waits in the poll register until the result register is free.
// Throughput: one item per cycle while the output is not stalled; the poll
// register and the result register (the target and direction state itself)
// form a two-stage pipeline, and order update and target choice are combinational.
// Reset: synchronous on aresetn low; orders clear, heading down, target -1.
module elevator_floor_scheduler #(
    parameter int FLOOR_COUNT = efs_pkg::DEFAULT_FLOOR_COUNT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [1:0] ctrl_state, [5:2] cab_buttons, [9:6] hall_up_buttons,
    // [13:10] hall_down_buttons, [16:14] last_floor, [19:17] current_floor
    input  logic [efs_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [3:0] target_floor (signed), [4] heading_up
    output logic [efs_pkg::M_TDATA_W-1:0] m_tdata
);

    efs_pkg::efs_item_t item_reg;
    logic               item_valid_reg;
    logic               m_valid_reg;
    logic               advance;

    logic signed [efs_pkg::TARGET_W-1:0] target_floor;
    logic                                heading_up;

    // The state registers double as the result register, so they may only
    // move once the previous result has gone.
    assign advance  = item_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !item_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (s_tready) begin
                item_valid_reg <= s_tvalid;
            end
            if (advance) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            item_reg <= efs_pkg::efs_item_t'(s_tdata[efs_pkg::ITEM_W-1:0]);
        end
    end

    efs_core #(
        .FLOOR_COUNT(FLOOR_COUNT)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (advance),
        .item        (item_reg),
        .target_floor(target_floor),
        .heading_up  (heading_up)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(efs_pkg::M_TDATA_W - efs_pkg::RESULT_W){1'b0}},
                       heading_up, target_floor};

endmodule

/* sv/efs_checks.sv */
// ----------------------------------------------------------------------------
// efs_checks
// Port-level checks for the elevator floor scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module efs_checks (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [efs_pkg::S_TDATA_W-1:0] s_tdata,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [efs_pkg::M_TDATA_W-1:0] m_tdata
);

    // A stalled result must hold.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // The target is either a real floor served by the buttons or no target.
    a_target_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[3:0] <= 4'd4) || (m_tdata[3:0] == 4'hF))
        else $error("target floor out of range");

    // A free output side must never hold back the input side.
    a_no_bubble: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("input stalled while the output is free");

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind elevator_floor_scheduler efs_checks u_efs_checks (.*);
